[sv/dws_pkg.sv]
// Shared types and constants for the deque with search.
package dws_pkg;

   // Fixed field widths of the request and response transactions
   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int OCC_W    = 5;

   // Default sizing of the queue
   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_SEARCH = 1'b1
   } state_type;

   // Controls broadcast to every cell in the chain
   typedef struct packed {
      logic shift_up;    // move every entry one place toward the back
      logic shift_down;  // move every entry one place toward the front
   } cell_ctrl_type;

endpackage

[sv/dws_cell.sv]
// One storage cell of the deque chain with its own key comparator.
module dws_cell #(
   parameter int DATA_WIDTH = dws_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                  clock,
   input  dws_pkg::cell_ctrl_type ctrl,
   input  logic                  write_en,
   input  logic [DATA_WIDTH-1:0] write_data,
   input  logic [DATA_WIDTH-1:0] from_lower,
   input  logic [DATA_WIDTH-1:0] from_upper,
   input  logic [DATA_WIDTH-1:0] key,
   input  logic                  in_use,
   output logic [DATA_WIDTH-1:0] data_out,
   output logic                  match
);
   import dws_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // Select the neighbor or the written value, else hold
   always_comb begin
      priority if (ctrl.shift_up) begin
         data_in = from_lower;
      end else if (ctrl.shift_down) begin
         data_in = from_upper;
      end else if (write_en) begin
         data_in = write_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Compare only entries that hold live data
   assign match    = in_use && (data_ff == key);
   assign data_out = data_ff;

endmodule

[sv/dws_first_match.sv]
// Captures the per-cell match flags and finds the first match from the front.
module dws_first_match #(
   parameter int DEPTH = dws_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                capture,
   input  logic [DEPTH-1:0]                    match,
   output logic                                found,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] position
);
   import dws_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DEPTH-1:0] match_ff;

   // Hold the flags of the search transaction
   always_ff @(posedge clock) begin
      if (capture) begin
         match_ff <= match;
      end
   end

   // Lowest set flag wins: scan from the back so the front overrides
   always_comb begin
      found    = 1'b0;
      position = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            found    = 1'b1;
            position = IDX_W'(i);
         end
      end
   end

endmodule

[sv/deque_with_search.sv]
// Top level: bounded double-ended queue with a parallel search over its cells.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_opcode, req_value
//   rsp      out        rsp_valid / rsp_stall  rsp_status, rsp_found,
//                                              rsp_found_position, rsp_occupancy
//
// On a push or a pop the chain of cells shifts or writes at the
// accepting edge and the response register loads at the same edge.
// On a search the match flags of the cells are captured at the accepting edge;
// the captured flags pass through the first-match encoder in the next cycle.
// Reset empties the queue; cell contents are not cleared.
// A stalled response holds the next request off until the response is taken.
module deque_with_search #(
   parameter int DEPTH      = dws_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = dws_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dws_pkg::OPCODE_W-1:0] req_opcode,
   input  logic signed [dws_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dws_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_found,
   output logic [dws_pkg::POS_W-1:0]    rsp_found_position,
   output logic [dws_pkg::OCC_W-1:0]    rsp_occupancy
);
   import dws_pkg::*;

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;

   logic                   accept;
   logic                   out_free;
   logic                   load_direct;
   logic                   load_search;
   logic                   capture;
   op_type                 op;
   logic                   full;
   logic                   empty;
   status_type             status;
   cell_ctrl_type          ctrl;
   logic                   push_back_ok;
   logic [DATA_WIDTH-1:0]  key;
   logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
   logic [DEPTH-1:0]       match;
   logic                   enc_found;
   logic [IDX_W-1:0]       enc_pos;
   logic [IDX_W+POS_W-1:0] pos_wide;
   logic [COUNT_W+OCC_W-1:0] occ_wide;
   logic [COUNT_W+OCC_W-1:0] occ_now_wide;

   // Fit the request value to the stored width
   generate
      if (DATA_WIDTH <= VALUE_W) begin : g_key_trunc
         assign key = req_value[DATA_WIDTH-1:0];
      end else begin : g_key_ext
         assign key = {{(DATA_WIDTH - VALUE_W){req_value[VALUE_W-1]}}, req_value};
      end
   endgenerate

   assign op       = op_type'(req_opcode);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (op == OP_SEARCH)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and load strobes
   always_comb begin
      req_stall   = 1'b1;
      load_direct = 1'b0;
      load_search = 1'b0;
      capture     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = !out_free;
            load_direct = req_valid && out_free && (op != OP_SEARCH);
            capture     = req_valid && out_free && (op == OP_SEARCH);
         end
         ST_SEARCH: begin
            load_search = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Decode the queue operation of the accepted transaction
   always_comb begin
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
      push_back_ok    = 1'b0;
      count_in        = count_ff;
      status          = STATUS_OK;
      if (accept) begin
         unique case (op)
            OP_PUSH_FRONT: begin
               if (full) begin
                  status = STATUS_FULL;
               end else begin
                  ctrl.shift_up = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  status = STATUS_FULL;
               end else begin
                  push_back_ok = 1'b1;
                  count_in     = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  ctrl.shift_down = 1'b1;
                  count_in        = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status = STATUS_OK;
            end
         endcase
      end
   end

   // Chain of cells, front at index zero
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] lower;
         logic [DATA_WIDTH-1:0] upper;
         if (i == 0) begin : g_first
            assign lower = key;
         end else begin : g_mid_lo
            assign lower = cell_data[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign upper = cell_data[i];
         end else begin : g_mid_hi
            assign upper = cell_data[i+1];
         end
         dws_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .write_en   (push_back_ok && (count_ff == COUNT_W'(i))),
            .write_data (key),
            .from_lower (lower),
            .from_upper (upper),
            .key        (key),
            .in_use     (COUNT_W'(i) < count_ff),
            .data_out   (cell_data[i]),
            .match      (match[i])
         );
      end
   endgenerate

   dws_first_match #(
      .DEPTH (DEPTH)
   ) u_first_match (
      .clock    (clock),
      .capture  (capture),
      .match    (match),
      .found    (enc_found),
      .position (enc_pos)
   );

   // Mask position and occupancy to the response field widths
   assign pos_wide     = {{POS_W{1'b0}}, enc_pos};
   assign occ_wide     = {{OCC_W{1'b0}}, count_in};
   assign occ_now_wide = {{OCC_W{1'b0}}, count_ff};

   // Load the response register, drop valid once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_occ_in    = rsp_occ_ff;
      priority if (load_direct) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_found_in  = 1'b0;
         rsp_pos_in    = '0;
         rsp_occ_in    = occ_wide[OCC_W-1:0];
      end else if (load_search) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_found_in  = enc_found;
         rsp_pos_in    = enc_found ? pos_wide[POS_W-1:0] : '0;
         rsp_occ_in    = occ_now_wide[OCC_W-1:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_occupancy      = rsp_occ_ff;

   // Occupancy never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // Occupancy moves only on an accepted transaction
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a transaction");

   // An accepted search enters the encode cycle
   a_search_seq: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_SEARCH)) |=> (state_ff == ST_SEARCH))
      else $error("search did not enter encode cycle");

   // Any other accepted transaction presents a response next cycle
   a_direct_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (op != OP_SEARCH)) |=> rsp_valid_ff)
      else $error("no response after push or pop");

endmodule
